/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file pids_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define PIDS_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pids assertion failed");

// Same, on the house clock and reset names.
`define PIDS_ASSERT(lbl, prop) `PIDS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* hw/rtl/pids_pkg.sv */
// Package for the permutation statistics block: sizes, token type, limits.
package pids_pkg;

  localparam int MAX_DEGREE = 128;
  localparam int VAL_W      = 8;
  localparam int IDX_W      = (MAX_DEGREE > 2) ? $clog2(MAX_DEGREE) : 1;
  localparam int CMP_W      = (IDX_W > VAL_W) ? IDX_W : VAL_W;
  localparam int INV_W      = 13;
  localparam int DES_W      = 7;
  localparam int MAJ_W      = 13;
  localparam int INV_SUM_W  = ((IDX_W > INV_W) ? IDX_W : INV_W) + 1;

  localparam logic [VAL_W-1:0] DEGREE_RESET = 8'd128;
  localparam logic [VAL_W-1:0] DEG_CAP =
    (MAX_DEGREE > 255) ? 8'd255 : VAL_W'(MAX_DEGREE);

  localparam logic [INV_W-1:0] INV_MAX = '1;
  localparam logic [DES_W-1:0] DES_MAX = '1;
  localparam logic [MAJ_W-1:0] MAJ_MAX = '1;

  // One entry as it travels along the cell chain.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic             ok;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] n;
    logic [IDX_W-1:0] above;
  } pids_tok_t;

endpackage

/* hw/rtl/pids_if.sv */
// Stream interfaces for the entry, result and configuration channels.
interface pids_in_if;
  import pids_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] entry_value;
  modport source (output valid, entry_value, input ready);
  modport sink   (input valid, entry_value, output ready);
endinterface

interface pids_out_if;
  import pids_pkg::*;
  logic             valid;
  logic             ready;
  logic             is_valid;
  logic [INV_W-1:0] inversions;
  logic [DES_W-1:0] descents;
  logic [MAJ_W-1:0] major_sum;
  modport source (output valid, is_valid, inversions, descents, major_sum, input ready);
  modport sink   (input valid, is_valid, inversions, descents, major_sum, output ready);
endinterface

interface pids_cfg_if;
  import pids_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/permutation_inversion_descent_stats.sv */
// Top level of the permutation inversion, descent and major index block.
// Entries of a permutation arrive one per request on ent_i, in position order, and one
// result request leaves on res_o after the last entry (degree set through cfg_i, clamped
// to 1..MAX_DEGREE). The block takes one entry every cycle while the chain advances.
// Each entry walks a chain of MAX_DEGREE cells, one cell per value, one cell per cycle;
// the cells hold the seen map and count earlier larger values on the way, and the tail
// registers the result when the last entry leaves the chain. The chain holds only when
// a finishing entry reaches its end while the previous result is still unread.
module permutation_inversion_descent_stats (
  input  logic       clk_i,
  input  logic       rst_ni,
  pids_cfg_if.sink   cfg_i,
  pids_in_if.sink    ent_i,
  pids_out_if.source res_o
);
  import pids_pkg::*;

  pids_tok_t tok [MAX_DEGREE+1];
  logic      adv;

  pids_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ent_i  (ent_i),
    .adv_i  (adv),
    .tok_o  (tok[0])
  );

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
    pids_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (IDX_W'(k)),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  pids_tail u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok[MAX_DEGREE]),
    .adv_o  (adv),
    .res_o  (res_o)
  );

endmodule

/* hw/rtl/pids_front.sv */
// Front end: degree register, position counter and chain token creation.
module pids_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pids_cfg_if.sink            cfg_i,
  pids_in_if.sink             ent_i,
  input  logic                adv_i,
  output pids_pkg::pids_tok_t tok_o
);
  import pids_pkg::*;

  logic [VAL_W-1:0] degree_q, degree_d;
  logic [VAL_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] n_eff;
  logic             last;
  logic             accept;

  assign cfg_i.ready = 1'b1;
  assign ent_i.ready = adv_i;
  assign accept      = ent_i.valid && adv_i;

  always_comb begin
    if (degree_q == '0) begin
      n_eff = VAL_W'(1);
    end else if (degree_q > DEG_CAP) begin
      n_eff = DEG_CAP;
    end else begin
      n_eff = degree_q;
    end
  end

  assign last = ({1'b0, pos_q} + 9'd1) >= {1'b0, n_eff};

  always_comb begin
    degree_d = cfg_i.valid ? cfg_i.data : degree_q;
    pos_d    = pos_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + VAL_W'(1);
    end
  end

  always_comb begin
    tok_o.vld   = accept;
    tok_o.last  = last;
    tok_o.ok    = ent_i.entry_value < n_eff;
    tok_o.value = ent_i.entry_value;
    tok_o.n     = n_eff;
    tok_o.above = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RESET;
      pos_q    <= '0;
    end else begin
      degree_q <= degree_d;
      pos_q    <= pos_d;
    end
  end

endmodule

/* hw/rtl/pids_cell.sv */
// One chain cell: owns the seen bit of one value and counts it for passing entries.
module pids_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic [pids_pkg::IDX_W-1:0] idx_i,
  input  pids_pkg::pids_tok_t    tok_i,
  output pids_pkg::pids_tok_t    tok_o
);
  import pids_pkg::*;

  logic      seen_q, seen_d;
  pids_tok_t tok_q, tok_d;
  logic      hit;
  logic      above_hit;

  assign hit       = tok_i.vld && (CMP_W'(tok_i.value) == CMP_W'(idx_i));
  assign above_hit = tok_i.vld && seen_q
                     && (CMP_W'(idx_i) > CMP_W'(tok_i.value))
                     && (CMP_W'(idx_i) < CMP_W'(tok_i.n));

  always_comb begin
    tok_d       = tok_i;
    tok_d.ok    = tok_i.ok && !(hit && seen_q);
    tok_d.above = tok_i.above + IDX_W'(above_hit);
    seen_d      = seen_q;
    // the final entry of a permutation wipes the map behind it
    if (tok_i.vld && tok_i.last) begin
      seen_d = 1'b0;
    end else if (hit && tok_i.ok) begin
      seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      tok_q  <= '0;
    end else if (adv_i) begin
      seen_q <= seen_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hw/rtl/pids_tail.sv */
// Tail: descent and major index tracking, sums, validity and the result register.
module pids_tail (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pids_pkg::pids_tok_t tok_i,
  output logic                adv_o,
  pids_out_if.source          res_o
);
  import pids_pkg::*;

  logic [INV_W-1:0] inv_q, inv_d;
  logic [DES_W-1:0] des_q, des_d;
  logic [MAJ_W-1:0] maj_q, maj_d;
  logic             flag_q, flag_d;
  logic [VAL_W-1:0] prev_q, prev_d;
  logic [VAL_W-1:0] pos_q, pos_d;

  logic             out_vld_q, out_vld_d;
  logic             out_ok_q;
  logic [INV_W-1:0] out_inv_q;
  logic [DES_W-1:0] out_des_q;
  logic [MAJ_W-1:0] out_maj_q;

  logic [INV_SUM_W-1:0] inv_ext;
  logic [DES_W:0]       des_ext;
  logic [MAJ_W:0]       maj_ext;
  logic [INV_W-1:0]     inv_n;
  logic [DES_W-1:0]     des_n;
  logic [MAJ_W-1:0]     maj_n;
  logic                 flag_n;
  logic                 is_desc;
  logic                 fire;
  logic                 finish;

  // only a finishing entry needs the result register free
  assign adv_o  = !(tok_i.vld && tok_i.last && out_vld_q && !res_o.ready);
  assign fire   = tok_i.vld && adv_o;
  assign finish = fire && tok_i.last;

  always_comb begin
    inv_ext = INV_SUM_W'(inv_q) + INV_SUM_W'(tok_i.above);
    des_ext = {1'b0, des_q} + (DES_W+1)'(1);
    maj_ext = {1'b0, maj_q} + (MAJ_W+1)'(pos_q);
    is_desc = (pos_q != '0) && (prev_q > tok_i.value);
    flag_n  = flag_q && tok_i.ok;
    inv_n   = inv_q;
    if (tok_i.ok) begin
      inv_n = (inv_ext > INV_SUM_W'(INV_MAX)) ? INV_MAX : inv_ext[INV_W-1:0];
    end
    des_n = des_q;
    maj_n = maj_q;
    if (is_desc) begin
      des_n = (des_ext > (DES_W+1)'(DES_MAX)) ? DES_MAX : des_ext[DES_W-1:0];
      maj_n = (maj_ext > (MAJ_W+1)'(MAJ_MAX)) ? MAJ_MAX : maj_ext[MAJ_W-1:0];
    end
  end

  always_comb begin
    inv_d  = inv_q;
    des_d  = des_q;
    maj_d  = maj_q;
    flag_d = flag_q;
    prev_d = prev_q;
    pos_d  = pos_q;
    if (fire) begin
      if (tok_i.last) begin
        inv_d  = '0;
        des_d  = '0;
        maj_d  = '0;
        flag_d = 1'b1;
        prev_d = '0;
        pos_d  = '0;
      end else begin
        inv_d  = inv_n;
        des_d  = des_n;
        maj_d  = maj_n;
        flag_d = flag_n;
        prev_d = tok_i.value;
        pos_d  = pos_q + VAL_W'(1);
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (finish) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= '0;
      des_q     <= '0;
      maj_q     <= '0;
      flag_q    <= 1'b1;
      prev_q    <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      inv_q     <= inv_d;
      des_q     <= des_d;
      maj_q     <= maj_d;
      flag_q    <= flag_d;
      prev_q    <= prev_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_ok_q  <= flag_n;
      out_inv_q <= flag_n ? inv_n : '0;
      out_des_q <= flag_n ? des_n : '0;
      out_maj_q <= flag_n ? maj_n : '0;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.is_valid   = out_ok_q;
  assign res_o.inversions = out_inv_q;
  assign res_o.descents   = out_des_q;
  assign res_o.major_sum  = out_maj_q;

endmodule

/* hw/rtl/pids_checker.sv */
// Port-level checker for the permutation statistics block, with its bind.
`include "assert_macros.svh"

module pids_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_is_valid_i,
  input logic [pids_pkg::INV_W-1:0] out_inversions_i,
  input logic [pids_pkg::DES_W-1:0] out_descents_i,
  input logic [pids_pkg::MAJ_W-1:0] out_major_sum_i
);
  import pids_pkg::*;

  logic stats_zero;
  assign stats_zero = (out_inversions_i == '0) && (out_descents_i == '0)
                      && (out_major_sum_i == '0);

  // a pending result is held until taken
  `PIDS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  // a rejected permutation reports no statistics
  `PIDS_ASSERT(a_invalid_zero, out_valid_i && !out_is_valid_i |-> stats_zero)
  // every descent sits at position one or later
  `PIDS_ASSERT(a_major_ge_des, out_valid_i |-> MAJ_W'(out_descents_i) <= out_major_sum_i)
  // with no result waiting the entry side never stalls
  `PIDS_ASSERT(a_ready_free, in_valid_i && !out_valid_i |-> in_ready_i)

endmodule

bind permutation_inversion_descent_stats pids_checker u_pids_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (ent_i.valid),
  .in_ready_i       (ent_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_is_valid_i   (res_o.is_valid),
  .out_inversions_i (res_o.inversions),
  .out_descents_i   (res_o.descents),
  .out_major_sum_i  (res_o.major_sum)
);
